// ----- hdl/ata_taskfile_command_builder_defines.svh -----
// Assertion macros shared by the task-file command builder RTL.
`ifndef ATA_TASKFILE_COMMAND_BUILDER_DEFINES_SVH
`define ATA_TASKFILE_COMMAND_BUILDER_DEFINES_SVH

`ifndef SYNTH
// Checked on every rising edge of clk, switched off while rst_n is low.
`define ATCB_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset cycles included.
`define ATCB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATCB_ASSERT_CLK(lbl, prop, msg)
`define ATCB_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- hdl/atcb_pkg.sv -----
// Types and constants of the ATA task-file command builder.
package atcb_pkg;

  // Addressing modes held in the mode register; any other code means CHS.
  localparam logic [1:0] ADDR_MODE_LBA28 = 2'd1;
  localparam logic [1:0] ADDR_MODE_LBA48 = 2'd2;

  // Configuration register select (word address bit).
  localparam logic CFG_SEL_MODE     = 1'b0;
  localparam logic CFG_SEL_CAPACITY = 1'b1;

  // Sector numbers at or above this value always use 48-bit addressing.
  localparam logic [31:0] FORCE_LBA48_AT = 32'h0FFF_FFFF;

  // CHS conversion: in CHS form the LBA is below 2^28, so lba / 63 is taken
  // as (lba * CHS_RECIP) >> CHS_SHIFT, exact over that whole range.
  localparam int              LBA_CHS_W = 28;
  localparam int              QUO_W     = 22;
  localparam int              PROD_W    = 57;
  localparam int              CHS_SHIFT = 34;
  localparam logic [28:0]     CHS_RECIP = 29'd272696337;

  // Register data bytes.
  localparam logic [7:0] SEL_CHS      = 8'hA0;
  localparam logic [7:0] SEL_LBA      = 8'hE0;
  localparam logic [7:0] OP_READ      = 8'h20;
  localparam logic [7:0] OP_READ_EXT  = 8'h24;
  localparam logic [7:0] OP_WRITE     = 8'h30;
  localparam logic [7:0] OP_WRITE_EXT = 8'h34;
  localparam logic [7:0] HOB_BIT      = 8'h80;
  localparam logic [7:0] NIEN_BIT     = 8'h02;

  // Register offsets.
  localparam logic [2:0] REG_DEVCTL  = 3'd2;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_LBA_LO  = 3'd3;
  localparam logic [2:0] REG_LBA_MID = 3'd4;
  localparam logic [2:0] REG_LBA_HI  = 3'd5;
  localparam logic [2:0] REG_SELECT  = 3'd6;
  localparam logic [2:0] REG_COMMAND = 3'd7;

  // Number of register writes per request.
  localparam logic [4:0] SEQ_LEN_SHORT = 5'd7;
  localparam logic [4:0] SEQ_LEN_LBA48 = 5'd19;

  // A checked and decoded request as handed to the write sequencer.
  typedef struct packed {
    logic             vld;
    logic             err;
    logic             lba48;
    logic             chs;
    logic             wr;
    logic             slave;
    logic [7:0]       cnt;
    logic [31:0]      lba;
    logic [QUO_W-1:0] quo;
  } atcb_req_t;

  // One register write, or the error result.
  typedef struct packed {
    logic       ctl;
    logic [2:0] off;
    logic [7:0] data;
    logic       status;
    logic       last;
  } atcb_res_t;

endpackage

// ----- hdl/atcb_seq.sv -----
// Write sequencer: steps through the register writes of one request.
module atcb_seq
  import atcb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  atcb_req_t req,
  output logic      done,
  output logic      res_vld,
  output atcb_res_t res
);

  logic [4:0]  step_r, step_nxt;
  logic [4:0]  slot;
  logic [4:0]  last_idx;
  logic [27:0] quo63;
  logic [27:0] rem;
  logic [7:0]  a0, a1, a2, sel, cmd;
  logic [3:0]  head;
  atcb_res_t   res_nxt;
  atcb_res_t   res_r;
  logic        res_vld_r;

  always_comb begin
    // Sector number within the track is lba - 63 * (lba / 63), plus one.
    quo63 = {req.quo, 6'b0} - {6'b0, req.quo};
    rem   = req.lba[LBA_CHS_W-1:0] - quo63;
    if (req.chs) begin
      a0   = {2'b0, rem[5:0]} + 8'd1;
      a1   = req.quo[11:4];
      a2   = req.quo[19:12];
      head = req.quo[3:0];
    end else begin
      a0   = req.lba[7:0];
      a1   = req.lba[15:8];
      a2   = req.lba[23:16];
      head = req.lba48 ? 4'd0 : req.lba[27:24];
    end
    sel = (req.chs ? SEL_CHS : SEL_LBA) | {3'b0, req.slave, 4'b0} | {4'b0, head};
    if (req.wr) begin
      cmd = req.lba48 ? OP_WRITE_EXT : OP_WRITE;
    end else begin
      cmd = req.lba48 ? OP_READ_EXT : OP_READ;
    end
    last_idx = req.lba48 ? (SEQ_LEN_LBA48 - 5'd1) : (SEQ_LEN_SHORT - 5'd1);
    // Short sequences skip the twelve high-order writes.
    slot = (req.lba48 || step_r < 5'd2) ? step_r : step_r + 5'd12;
  end

  always_comb begin
    res_nxt = '0;
    case (slot)
      5'd0: begin
        res_nxt.ctl = 1'b1; res_nxt.off = REG_DEVCTL; res_nxt.data = NIEN_BIT;
      end
      5'd1: begin
        res_nxt.off = REG_SELECT; res_nxt.data = sel;
      end
      5'd2, 5'd5, 5'd8, 5'd11: begin
        res_nxt.ctl = 1'b1; res_nxt.off = REG_DEVCTL; res_nxt.data = HOB_BIT | NIEN_BIT;
      end
      5'd4, 5'd7, 5'd10, 5'd13: begin
        res_nxt.ctl = 1'b1; res_nxt.off = REG_DEVCTL; res_nxt.data = NIEN_BIT;
      end
      5'd3: begin
        res_nxt.off = REG_COUNT; res_nxt.data = 8'd0;
      end
      5'd6: begin
        res_nxt.off = REG_LBA_LO; res_nxt.data = req.lba[31:24];
      end
      5'd9: begin
        res_nxt.off = REG_LBA_MID; res_nxt.data = 8'd0;
      end
      5'd12: begin
        res_nxt.off = REG_LBA_HI; res_nxt.data = 8'd0;
      end
      5'd14: begin
        res_nxt.off = REG_COUNT; res_nxt.data = req.cnt;
      end
      5'd15: begin
        res_nxt.off = REG_LBA_LO; res_nxt.data = a0;
      end
      5'd16: begin
        res_nxt.off = REG_LBA_MID; res_nxt.data = a1;
      end
      5'd17: begin
        res_nxt.off = REG_LBA_HI; res_nxt.data = a2;
      end
      5'd18: begin
        res_nxt.off = REG_COMMAND; res_nxt.data = cmd;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
    res_nxt.last = (step_r == last_idx);
    if (req.err) begin
      res_nxt        = '0;
      res_nxt.status = 1'b1;
      res_nxt.last   = 1'b1;
    end
  end

  assign done = req.vld && (req.err || step_r == last_idx);

  always_comb begin
    if (done) begin
      step_nxt = 5'd0;
    end else if (req.vld) begin
      step_nxt = step_r + 5'd1;
    end else begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= 5'd0;
      res_vld_r <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      res_vld_r <= req.vld;
    end
    res_r <= res_nxt;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

// ----- hdl/ata_taskfile_command_builder.sv -----
// Top level of the ATA task-file command builder.
//
//   channel   handshake                     payload
//   -------   ---------------------------   ------------------------------------
//   request   start / busy                  in_start_sector, in_sector_count,
//                                           in_is_write, in_slave_drive
//   writes    out_valid                     out_to_control_block, out_reg_offset,
//                                           out_write_data, out_status, out_last
//   config    APB psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
// A request is transferred on an edge with start high and busy low. It passes
// the input, decode and output registers; then its writes leave one per cycle:
// 19 in LBA48 form, 7 in CHS or LBA28 form, or one error result past capacity.
// busy is high only while a second request waits behind the one being written.
// The receiver cannot stall the outputs. rst_n is synchronous and active low
// and clears both configuration registers.
`include "ata_taskfile_command_builder_defines.svh"

module ata_taskfile_command_builder
  import atcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_start_sector,
  input  logic [7:0]  in_sector_count,
  input  logic        in_is_write,
  input  logic        in_slave_drive,
  // Register write channel.
  output logic        out_valid,
  output logic        out_to_control_block,
  output logic [2:0]  out_reg_offset,
  output logic [7:0]  out_write_data,
  output logic        out_status,
  output logic        out_last,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers. Register 0 sits at byte address 0 and register 1
  // at byte address 4; only the word address bit selects between them.
  logic [1:0]  mode_r;
  logic [31:0] cap_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0;
      cap_r  <= 32'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_SEL_MODE) begin
        mode_r <= pwdata[1:0];
      end
      if (paddr[2] == CFG_SEL_CAPACITY) begin
        cap_r <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == CFG_SEL_CAPACITY) ? cap_r : {30'b0, mode_r};

  // Input stage: the request as it was transferred.
  logic        s1_vld_r, s1_vld_nxt;
  logic [31:0] s1_lba_r;
  logic [7:0]  s1_cnt_r;
  logic        s1_wr_r;
  logic        s1_slave_r;
  logic        accept;
  logic        s1_move;
  logic        s2_free;
  logic        seq_done;

  // Decode stage: capacity check, addressing form and the CHS quotient.
  logic [32:0]       end_sector;
  logic              s1_err;
  logic              s1_lba48;
  logic              s1_lba28;
  logic [PROD_W-1:0] chs_prod;
  atcb_req_t         s2_r, s2_nxt;

  atcb_res_t res;
  logic      res_vld;

  assign s2_free = !s2_r.vld || seq_done;
  assign s1_move = s1_vld_r && s2_free;
  assign busy    = s1_vld_r && !s2_free;
  assign accept  = start && !busy;

  always_comb begin
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_move) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    if (accept) begin
      s1_lba_r   <= in_start_sector;
      s1_cnt_r   <= in_sector_count;
      s1_wr_r    <= in_is_write;
      s1_slave_r <= in_slave_drive;
    end
  end

  always_comb begin
    // The end of the request is compared with a 33-bit sum so it cannot wrap.
    end_sector = {1'b0, s1_lba_r} + {25'b0, s1_cnt_r};
    s1_err     = end_sector > {1'b0, cap_r};
    s1_lba48   = (mode_r == ADDR_MODE_LBA48) || (s1_lba_r >= FORCE_LBA48_AT);
    s1_lba28   = !s1_lba48 && (mode_r == ADDR_MODE_LBA28);
    // CHS is only used for sectors below 2^28, so 28 bits of the LBA suffice.
    chs_prod   = PROD_W'(s1_lba_r[LBA_CHS_W-1:0]) * PROD_W'(CHS_RECIP);

    s2_nxt = s2_r;
    if (s1_move) begin
      s2_nxt.vld   = 1'b1;
      s2_nxt.err   = s1_err;
      s2_nxt.lba48 = s1_lba48;
      s2_nxt.chs   = !s1_lba48 && !s1_lba28;
      s2_nxt.wr    = s1_wr_r;
      s2_nxt.slave = s1_slave_r;
      s2_nxt.cnt   = s1_cnt_r;
      s2_nxt.lba   = s1_lba_r;
      s2_nxt.quo   = chs_prod[CHS_SHIFT +: QUO_W];
    end else if (seq_done) begin
      s2_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else begin
      s2_r.vld <= s2_nxt.vld;
    end
    s2_r.err   <= s2_nxt.err;
    s2_r.lba48 <= s2_nxt.lba48;
    s2_r.chs   <= s2_nxt.chs;
    s2_r.wr    <= s2_nxt.wr;
    s2_r.slave <= s2_nxt.slave;
    s2_r.cnt   <= s2_nxt.cnt;
    s2_r.lba   <= s2_nxt.lba;
    s2_r.quo   <= s2_nxt.quo;
  end

  // The sequencer walks the decoded request one register write per cycle and
  // signals done in the cycle it computes the final write, before registering it.
  atcb_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (s2_r),
    .done    (seq_done),
    .res_vld (res_vld),
    .res     (res)
  );

  assign out_valid            = res_vld;
  assign out_to_control_block = res.ctl;
  assign out_reg_offset       = res.off;
  assign out_write_data       = res.data;
  assign out_status           = res.status;
  assign out_last             = res.last;

  // An error result stands alone and carries no register write.
  `ATCB_ASSERT_CLK(a_err, out_valid && out_status |-> out_last && !out_to_control_block, "error result")
  // Writes of one request leave back to back with no gap.
  `ATCB_ASSERT_CLK(a_no_gap, out_valid && !out_last |=> out_valid, "gap inside a write sequence")
  // A transferred request is always held in the input stage.
  `ATCB_ASSERT_CLK(a_accept_held, start && !busy |=> s1_vld_r, "transferred request was dropped")
  // A finished request with nothing waiting leaves the decode stage empty.
  `ATCB_ASSERT_CLK(a_stage_frees, s2_r.vld && seq_done && !s1_vld_r |=> !s2_r.vld, "stage stuck")
  // Reset leaves the block quiet and ready.
  `ATCB_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid && !busy, "outputs active after reset")

endmodule

// ----- verif/atcb_checker.sv -----
// Checker for the task-file command builder: predicts register writes and compares them.
`timescale 1ns / 100ps

module atcb_checker
  import atcb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [31:0]       in_start_sector,
  input  logic [7:0]        in_sector_count,
  input  logic              in_is_write,
  input  logic              in_slave_drive,
  input  logic              out_valid,
  input  logic              out_to_control_block,
  input  logic [2:0]        out_reg_offset,
  input  logic [7:0]        out_write_data,
  input  logic              out_status,
  input  logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output int unsigned       mismatches,
  output int unsigned       writes_pending
);

  localparam int unsigned SECTORS_PER_TRACK  = 63;
  localparam int unsigned HEADS_PER_CYLINDER = 16;

  logic [1:0]  mode_q = '0;
  logic [31:0] capacity_q = '0;
  atcb_res_t   expected_writes[$];
  int unsigned fail_count = 0;
  int unsigned pending_count = 0;

  assign mismatches     = fail_count;
  assign writes_pending = pending_count;

  function automatic atcb_res_t reg_write(input logic ctl, input logic [2:0] off,
                                          input logic [7:0] data);
    atcb_res_t w;
    w        = '0;
    w.ctl    = ctl;
    w.off    = off;
    w.data   = data;
    return w;
  endfunction

  // Expected bus writes for one request, given the current mode and capacity.
  task automatic predict_taskfile(input logic [31:0] lba, input logic [7:0] cnt,
                                  input logic wr, input logic slave);
    logic [32:0] span;
    logic        lba48;
    logic        chs;
    logic [31:0] track;
    logic [31:0] cyl;
    logic [31:0] sect;
    logic [3:0]  head;
    logic [7:0]  a0, a1, a2, sel, opcode;
    logic [2:0]  hob_off;
    atcb_res_t   err_res;
    span = {1'b0, lba} + {25'd0, cnt};
    if (span > {1'b0, capacity_q}) begin
      err_res        = '0;
      err_res.status = 1'b1;
      err_res.last   = 1'b1;
      expected_writes.push_back(err_res);
    end else begin
      lba48 = (mode_q == ADDR_MODE_LBA48) || (lba >= FORCE_LBA48_AT);
      chs   = !lba48 && (mode_q != ADDR_MODE_LBA28);
      if (chs) begin
        track = lba / SECTORS_PER_TRACK;
        cyl   = lba / (SECTORS_PER_TRACK * HEADS_PER_CYLINDER);
        sect  = lba % SECTORS_PER_TRACK + 1;
        a0    = sect[7:0];
        a1    = cyl[7:0];
        a2    = cyl[15:8];
        head  = track[3:0];
      end else begin
        a0   = lba[7:0];
        a1   = lba[15:8];
        a2   = lba[23:16];
        head = lba48 ? 4'd0 : lba[27:24];
      end
      sel = (chs ? SEL_CHS : SEL_LBA) | {3'b000, slave, head};
      if (lba48)
        opcode = wr ? OP_WRITE_EXT : OP_READ_EXT;
      else
        opcode = wr ? OP_WRITE : OP_READ;

      expected_writes.push_back(reg_write(1'b1, REG_DEVCTL, NIEN_BIT));
      expected_writes.push_back(reg_write(1'b0, REG_SELECT, sel));
      if (lba48) begin
        // High-order bytes go out with the HOB bit set around each one.
        for (int k = 0; k < 4; k++) begin
          hob_off = REG_COUNT + 3'(k);
          expected_writes.push_back(reg_write(1'b1, REG_DEVCTL, HOB_BIT | NIEN_BIT));
          expected_writes.push_back(reg_write(1'b0, hob_off,
                                              (hob_off == REG_LBA_LO) ? lba[31:24] : 8'h00));
          expected_writes.push_back(reg_write(1'b1, REG_DEVCTL, NIEN_BIT));
        end
      end
      expected_writes.push_back(reg_write(1'b0, REG_COUNT, cnt));
      expected_writes.push_back(reg_write(1'b0, REG_LBA_LO, a0));
      expected_writes.push_back(reg_write(1'b0, REG_LBA_MID, a1));
      expected_writes.push_back(reg_write(1'b0, REG_LBA_HI, a2));
      expected_writes.push_back(reg_write(1'b0, REG_COMMAND, opcode));
      expected_writes[expected_writes.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    atcb_res_t exp_w;
    if (!rst_n) begin
      mode_q     = '0;
      capacity_q = '0;
      expected_writes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == CFG_SEL_CAPACITY)
          capacity_q = pwdata;
        else
          mode_q = pwdata[1:0];
      end
      if (out_valid) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: expected no write actual ctl %0b off %0d data %0h st %0b last %0b",
                   $time, out_to_control_block, out_reg_offset, out_write_data,
                   out_status, out_last);
          fail_count++;
        end else begin
          exp_w = expected_writes.pop_front();
          check_field("to_control_block", {7'd0, exp_w.ctl}, {7'd0, out_to_control_block});
          check_field("reg_offset", {5'd0, exp_w.off}, {5'd0, out_reg_offset});
          check_field("write_data", exp_w.data, out_write_data);
          check_field("status", {7'd0, exp_w.status}, {7'd0, out_status});
          check_field("last", {7'd0, exp_w.last}, {7'd0, out_last});
        end
      end
      if (start && !busy)
        predict_taskfile(in_start_sector, in_sector_count, in_is_write, in_slave_drive);
    end
    pending_count = expected_writes.size();
  end

endmodule

// ----- verif/tb_ata_taskfile_command_builder.sv -----
// Top of the task-file command builder testbench: stimulus, configuration and verdict.
`timescale 1ns / 100ps

module tb_ata_taskfile_command_builder;
  import atcb_pkg::*;

  // Mode codes the package leaves unnamed: plain CHS and the spare code.
  localparam logic [1:0] ADDR_MODE_CHS    = 2'd0;
  localparam logic [1:0] ADDR_MODE_UNUSED = 2'd3;

  // Registers sit at byte addresses 0 and 4; the word select is address bit 2.
  localparam logic [2:0] MODE_REG_ADDR     = {CFG_SEL_MODE, 2'b00};
  localparam logic [2:0] CAPACITY_REG_ADDR = {CFG_SEL_CAPACITY, 2'b00};

  localparam logic [31:0] FULL_CAPACITY = 32'hFFFF_FFFF;

  // The limit leaves ample room for about 470 requests of at most 19 writes each, plus gaps.
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 56;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_start_sector = '0;
  logic [7:0]  in_sector_count = '0;
  logic        in_is_write = 1'b0;
  logic        in_slave_drive = 1'b0;
  logic        out_valid;
  logic        out_to_control_block;
  logic [2:0]  out_reg_offset;
  logic [7:0]  out_write_data;
  logic        out_status;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned writes_pending;
  int unsigned cycle_count = 0;

  // Capacity last programmed, used only to aim requests at the range boundary.
  logic [31:0] cur_capacity = '0;

  ata_taskfile_command_builder i_dut (.*);

  // The checker sits beside the block, watching both channels and the config port.
  atcb_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops writes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ata_taskfile_command_builder: mismatch");
      $finish;
    end
  end

  // One APB write: setup cycle, then access cycle until pready. A trailing idle
  // cycle keeps psel from being dropped and raised in the same time step.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every predicted write has come out, then let the pipeline drain.
  // The request strobe must already be low when this is called.
  task automatic wait_idle();
    while (writes_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers change only while the block is idle.
  task automatic configure(input logic [1:0] mode, input logic [31:0] capacity);
    wait_idle();
    write_register(MODE_REG_ADDR, {30'd0, mode});
    write_register(CAPACITY_REG_ADDR, capacity);
    cur_capacity = capacity;
  endtask

  // Presents one request and holds it until the transfer edge (start high, busy
  // low). With a gap of zero the strobe stays high for the next request, which
  // must then be issued in the same time step; otherwise it drops and the
  // sender idles for the gap.
  task automatic send_request(input logic [31:0] lba, input logic [7:0] cnt,
                              input logic wr, input logic slave,
                              input int unsigned gap);
    start           <= 1'b1;
    in_start_sector <= lba;
    in_sector_count <= cnt;
    in_is_write     <= wr;
    in_slave_drive  <= slave;
    do @(posedge clk); while (busy);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int unsigned pick;
    logic [31:0] lba;
    logic [7:0]  cnt;
    logic [1:0]  mode;
    logic [31:0] capacity;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Reset values first: with zero capacity only an empty
    // request at sector zero fits, and one sector more is out of range.
    send_request(32'd0, 8'd0, 1'b0, 1'b0, 1);
    send_request(32'd0, 8'd1, 1'b1, 1'b1, 2);

    // CHS around the track and cylinder boundaries, the largest CHS sector
    // (cylinder wraps), the first sector that forces LBA48, and the 33-bit
    // capacity sum at the very top of the address space.
    configure(ADDR_MODE_CHS, FULL_CAPACITY);
    send_request(32'd0, 8'd255, 1'b0, 1'b0, 0);
    send_request(32'd62, 8'd1, 1'b1, 1'b0, 0);
    send_request(32'd63, 8'd1, 1'b0, 1'b1, 0);
    send_request(32'd1007, 8'd2, 1'b0, 1'b0, 1);
    send_request(32'd1008, 8'd3, 1'b1, 1'b1, 1);
    send_request(32'h0FFF_FFFE, 8'd255, 1'b1, 1'b1, 1);
    send_request(32'h0FFF_FFFF, 8'd0, 1'b0, 1'b0, 1);
    send_request(32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1, 1);
    send_request(32'hFFFF_FFFF, 8'd1, 1'b0, 1'b0, 1);
    send_request(32'hFFFF_FF00, 8'd255, 1'b1, 1'b0, 1);

    // Requests ending exactly at and one past a small capacity.
    configure(ADDR_MODE_LBA28, 32'd1000);
    send_request(32'd990, 8'd10, 1'b0, 1'b1, 0);
    send_request(32'd990, 8'd11, 1'b1, 1'b0, 1);
    send_request(32'd999, 8'd0, 1'b1, 1'b1, 1);

    configure(ADDR_MODE_LBA48, FULL_CAPACITY);
    send_request(32'h1234_5678, 8'hA5, 1'b0, 1'b0, 0);
    send_request(32'd1, 8'd1, 1'b1, 1'b1, 1);

    // The spare mode code falls back to CHS unless the sector forces LBA48.
    configure(ADDR_MODE_UNUSED, FULL_CAPACITY);
    send_request(32'd5000, 8'd7, 1'b1, 1'b0, 1);
    send_request(32'h0FFF_FFFF, 8'd1, 1'b1, 1'b1, 1);

    configure(ADDR_MODE_LBA28, FULL_CAPACITY);
    send_request(32'h0FFF_FFFE, 8'd128, 1'b0, 1'b1, 0);
    send_request(32'h0ABC_DEF1, 8'h55, 1'b1, 1'b0, 1);

    // Random part: one setting per phase, extremes of capacity among them.
    burst_left = $urandom_range(1, 24);
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin mode = ADDR_MODE_CHS;    capacity = FULL_CAPACITY; end
        1: begin mode = ADDR_MODE_LBA28;  capacity = FULL_CAPACITY; end
        2: begin mode = ADDR_MODE_LBA48;  capacity = FULL_CAPACITY; end
        3: begin mode = ADDR_MODE_UNUSED; capacity = $urandom; end
        4: begin mode = ADDR_MODE_CHS;    capacity = $urandom_range(0, 32'h0FFF_FFFF); end
        5: begin mode = ADDR_MODE_LBA28;  capacity = 32'd0; end
        6: begin mode = ADDR_MODE_LBA48;  capacity = $urandom; end
        default: begin
          mode     = 2'($urandom_range(0, 3));
          capacity = FULL_CAPACITY;
        end
      endcase
      configure(mode, capacity);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        cnt  = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        // Sector classes: the CHS/LBA28 range, the LBA48 forcing boundary, any
        // value, low sectors, and requests that end right at the capacity.
        if (pick < 35)
          lba = $urandom_range(0, 32'h0FFF_FFFE);
        else if (pick < 50)
          lba = FORCE_LBA48_AT - 32'd4 + 32'($urandom_range(0, 8));
        else if (pick < 65)
          lba = $urandom;
        else if (pick < 80)
          lba = $urandom_range(0, 5000);
        else
          lba = cur_capacity - {24'd0, cnt} - 32'd2 + 32'($urandom_range(0, 4));

        // Bursts of back-to-back transfers separated by random idle gaps; the
        // phase always ends with the strobe low so the block can drain.
        burst_left--;
        if (burst_left == 0 || i == ITEMS_PER_PHASE - 1) begin
          gap        = $urandom_range(1, 12);
          burst_left = $urandom_range(1, 24);
        end else begin
          gap = 0;
        end
        send_request(lba, cnt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gap);
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("ata_taskfile_command_builder: match");
    else
      $display("ata_taskfile_command_builder: mismatch");
    $finish;
  end

endmodule
